>>> hw/rtl/blend_vector_by_clockwise_rotation_assert.svh
// Assertion macros shared by the blend_vector_by_clockwise_rotation RTL.
`ifndef BLEND_VECTOR_BY_CLOCKWISE_ROTATION_ASSERT_SVH
`define BLEND_VECTOR_BY_CLOCKWISE_ROTATION_ASSERT_SVH
`ifndef SYNTHESIS
`define BVCR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define BVCR_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);
`else
`define BVCR_ASSERT(lbl, prop, msg)
`define BVCR_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

>>> hw/rtl/bvcr_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the vector blend.
package bvcr_pkg;

   localparam int COORD_WIDTH_DEF   = 32;
   localparam int CORDIC_STAGES_DEF = 24;
   localparam int QUEUE_DEPTH       = 4;

   // Internal vector width of the vectoring CORDIC (prescaled x,y plus gain growth).
   localparam int VEC_W   = 36;
   localparam int SHIFT_W = 5;

   localparam logic [29:0] KINV_Q30     = 30'd652032874;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   typedef struct packed {
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [31:0] to_x;
      logic signed [31:0] to_y;
      logic signed [15:0] blend_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               degenerate;
   } rsp_type;

   // Queue entry: classified, prescaled and quadrant-folded item.
   typedef struct packed {
      logic                     degen;
      logic signed [31:0]       from_x;
      logic signed [31:0]       from_y;
      logic signed [VEC_W-1:0]  fx;
      logic signed [VEC_W-1:0]  fy;
      logic [31:0]              fz;
      logic [SHIFT_W-1:0]       fs;
      logic signed [VEC_W-1:0]  tx;
      logic signed [VEC_W-1:0]  ty;
      logic [31:0]              tz;
      logic [SHIFT_W-1:0]       ts;
      logic signed [15:0]       rate;
   } job_type;

   // atan(2^-i) in units of 2^-32 turn.
   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/bvcr_chan_if.sv
// Valid/ready channel interface carrying one payload item per transfer.
interface bvcr_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/bvcr_front.sv
// Front end: takes requests, flags zero-length vectors, prescales and folds quadrants.
`include "blend_vector_by_clockwise_rotation_assert.svh"
module bvcr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bvcr_pkg::req_type in_data,
   output logic              push,
   output bvcr_pkg::job_type push_data,
   input  logic              full
);

   typedef struct packed {
      logic signed [bvcr_pkg::VEC_W-1:0] x;
      logic signed [bvcr_pkg::VEC_W-1:0] y;
      logic [31:0]                       z;
      logic [bvcr_pkg::SHIFT_W-1:0]      s;
   } vinit_type;

   logic              valid_ff;
   bvcr_pkg::req_type data_ff;
   vinit_type         fv;
   vinit_type         tv;

   // Scale so max(|x|,|y|) lands in [2^30,2^31], then fold left half-plane by a quarter turn.
   function automatic vinit_type prep(input logic signed [31:0] x, input logic signed [31:0] y);
      logic [32:0]                       ax;
      logic [32:0]                       ay;
      logic [32:0]                       m;
      logic [4:0]                        p;
      logic [bvcr_pkg::SHIFT_W-1:0]      s;
      logic signed [bvcr_pkg::VEC_W-1:0] xs;
      logic signed [bvcr_pkg::VEC_W-1:0] ys;
      vinit_type                         r;
      ax = x[31] ? (33'd0 - {x[31], x}) : {1'b0, x};
      ay = y[31] ? (33'd0 - {y[31], y}) : {1'b0, y};
      m  = (ax > ay) ? ax : ay;
      p  = '0;
      for (int b = 0; b < 32; b++) begin
         if (m[b]) p = 5'(b);
      end
      s  = (p >= 5'd30) ? '0 : (5'd30 - p);
      xs = bvcr_pkg::VEC_W'(x) <<< s;
      ys = bvcr_pkg::VEC_W'(y) <<< s;
      r.s = s;
      if (xs < 0) begin
         if (ys >= 0) begin
            r.x = ys;
            r.y = -xs;
            r.z = bvcr_pkg::QUARTER_TURN;
         end else begin
            r.x = -ys;
            r.y = xs;
            r.z = 32'd0 - bvcr_pkg::QUARTER_TURN;
         end
      end else begin
         r.x = xs;
         r.y = ys;
         r.z = '0;
      end
      return r;
   endfunction

   assign in_ready = !valid_ff || !full;
   assign push     = valid_ff && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   always_comb begin
      fv = prep(data_ff.from_x, data_ff.from_y);
      tv = prep(data_ff.to_x, data_ff.to_y);
      push_data.degen  = (data_ff.from_x == 0 && data_ff.from_y == 0) ||
                         (data_ff.to_x == 0 && data_ff.to_y == 0);
      push_data.from_x = data_ff.from_x;
      push_data.from_y = data_ff.from_y;
      push_data.fx     = fv.x;
      push_data.fy     = fv.y;
      push_data.fz     = fv.z;
      push_data.fs     = fv.s;
      push_data.tx     = tv.x;
      push_data.ty     = tv.y;
      push_data.tz     = tv.z;
      push_data.ts     = tv.s;
      push_data.rate   = data_ff.blend_rate;
   end

   `BVCR_ASSERT_NEXT(a_front_load, in_valid && in_ready, valid_ff, "front: transfer not held")

endmodule

>>> hw/rtl/bvcr_fifo.sv
// Short job queue between the front end and the CORDIC back end.
`include "blend_vector_by_clockwise_rotation_assert.svh"
module bvcr_fifo #(
   parameter int DEPTH = bvcr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bvcr_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output bvcr_pkg::job_type pop_data,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bvcr_pkg::job_type  mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BVCR_ASSERT(a_fifo_bound, count_ff <= CNT_W'(DEPTH), "fifo: count above depth")
   `BVCR_ASSERT_NEXT(a_fifo_drain, pop && !push, count_ff == $past(count_ff) - 1'b1, "fifo: drain lost")

endmodule

>>> hw/rtl/bvcr_back.sv
// Back end: vectoring CORDIC, angle blend, rotation CORDIC, length rescale, saturation.
`include "blend_vector_by_clockwise_rotation_assert.svh"
module bvcr_back #(
   parameter int COORD_WIDTH   = bvcr_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = bvcr_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  bvcr_pkg::job_type job_data,
   output logic              job_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output bvcr_pkg::rsp_type out_data
);

   localparam int N     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int VW    = bvcr_pkg::VEC_W;
   localparam int SW    = bvcr_pkg::SHIFT_W;
   localparam int ROT_W = 34;
   localparam int LEN_W = 50;
   localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
   localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (SAT_W - 1)) - 66'sd1;
   localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;
   localparam logic signed [33:0] QTR    = 34'(bvcr_pkg::QUARTER_TURN);

   typedef struct packed {
      logic               degen;
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic [47:0]        pf_hi;
      logic [46:0]        pf_lo;
      logic [47:0]        pt_hi;
      logic [46:0]        pt_lo;
      logic [SW-1:0]      fs;
      logic [SW-1:0]      ts;
      logic [31:0]        af;
      logic signed [33:0] d;
      logic signed [15:0] rate;
   } p0_type;

   typedef struct packed {
      logic               degen;
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic [LEN_W-1:0]   lf;
      logic [LEN_W-1:0]   lt;
      logic [31:0]        af;
      logic signed [49:0] rprod;
   } p1_type;

   typedef struct packed {
      logic                    degen;
      logic signed [31:0]      from_x;
      logic signed [31:0]      from_y;
      logic [LEN_W-1:0]        mean;
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [33:0]      phi;
   } rot_type;

   typedef struct packed {
      logic                    degen;
      logic signed [31:0]      from_x;
      logic signed [31:0]      from_y;
      logic [30:0]             t;
      logic [4:0]              e;
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
   } n0_type;

   typedef struct packed {
      logic               degen;
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [65:0] px;
      logic signed [65:0] py;
      logic [4:0]         e;
   } m0_type;

   logic                adv;
   bvcr_pkg::job_type   vs_ff [0:N];
   bvcr_pkg::job_type   vs_in [0:N];
   logic [N:0]          vv_ff;
   p0_type              p0_ff, p0_in;
   logic                p0_v_ff;
   p1_type              p1_ff, p1_in;
   logic                p1_v_ff;
   rot_type             rs_ff [0:N];
   rot_type             rs_in [0:N];
   logic [N:0]          rv_ff;
   n0_type              n0_ff, n0_in;
   logic                n0_v_ff;
   m0_type              m0_ff, m0_in;
   logic                m0_v_ff;
   bvcr_pkg::rsp_type   out_ff, out_in;
   logic                out_v_ff;

   function automatic logic [31:0] sat(input logic signed [65:0] v);
      logic signed [65:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      if (v < SAT_LO) r = SAT_LO;
      return r[31:0];
   endfunction

   // One vectoring micro-rotation on both vectors: drive y toward zero.
   function automatic bvcr_pkg::job_type vec_step(input bvcr_pkg::job_type j, input logic [4:0] k);
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic [31:0]          a;
      bvcr_pkg::job_type    r;
      r = j;
      a = bvcr_pkg::atan_turns(k);
      x = j.fx;
      y = j.fy;
      if (y > 0) begin
         r.fx = x + (y >>> k);
         r.fy = y - (x >>> k);
         r.fz = j.fz + a;
      end else begin
         r.fx = x - (y >>> k);
         r.fy = y + (x >>> k);
         r.fz = j.fz - a;
      end
      x = j.tx;
      y = j.ty;
      if (y > 0) begin
         r.tx = x + (y >>> k);
         r.ty = y - (x >>> k);
         r.tz = j.tz + a;
      end else begin
         r.tx = x - (y >>> k);
         r.ty = y + (x >>> k);
         r.tz = j.tz - a;
      end
      return r;
   endfunction

   // One rotation micro-rotation: drive the residual angle toward zero.
   function automatic rot_type rot_step(input rot_type j, input logic [4:0] k);
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [33:0]      ph;
      logic signed [33:0]      a;
      rot_type                 r;
      r  = j;
      x  = j.x;
      y  = j.y;
      ph = j.phi;
      a  = $signed({2'b00, bvcr_pkg::atan_turns(k)});
      if (ph >= 0) begin
         r.x   = x - (y >>> k);
         r.y   = y + (x >>> k);
         r.phi = ph - a;
      end else begin
         r.x   = x + (y >>> k);
         r.y   = y - (x >>> k);
         r.phi = ph + a;
      end
      return r;
   endfunction

   // The whole pipeline advances together; it freezes only while the result is held.
   assign adv       = !out_v_ff || out_ready;
   assign job_pop   = job_valid && adv;
   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

   always_comb begin
      vs_in[0] = job_data;
      for (int k = 0; k < N; k++) begin
         vs_in[k+1] = vec_step(vs_ff[k], 5'(k));
      end
   end

   // Gain removal split in two partial products; angle difference made clockwise.
   always_comb begin
      logic [34:0]        xf;
      logic [34:0]        xt;
      logic signed [33:0] dd;
      xf = vs_ff[N].fx[34:0];
      xt = vs_ff[N].tx[34:0];
      dd = 34'($signed(vs_ff[N].tz)) - 34'($signed(vs_ff[N].fz));
      if (dd >= 0) dd = dd - 34'sh1_0000_0000;
      p0_in.degen  = vs_ff[N].degen;
      p0_in.from_x = vs_ff[N].from_x;
      p0_in.from_y = vs_ff[N].from_y;
      p0_in.pf_hi  = 48'(xf[34:17]) * 48'(bvcr_pkg::KINV_Q30);
      p0_in.pf_lo  = 47'(xf[16:0]) * 47'(bvcr_pkg::KINV_Q30);
      p0_in.pt_hi  = 48'(xt[34:17]) * 48'(bvcr_pkg::KINV_Q30);
      p0_in.pt_lo  = 47'(xt[16:0]) * 47'(bvcr_pkg::KINV_Q30);
      p0_in.fs     = vs_ff[N].fs;
      p0_in.ts     = vs_ff[N].ts;
      p0_in.af     = vs_ff[N].fz;
      p0_in.d      = dd;
      p0_in.rate   = vs_ff[N].rate;
   end

   // Lengths undo the prescale; the clockwise angle is scaled by the rate.
   always_comb begin
      logic [63:0] sf;
      logic [63:0] st;
      sf = (64'(p0_ff.pf_hi) << 17) + 64'(p0_ff.pf_lo);
      st = (64'(p0_ff.pt_hi) << 17) + 64'(p0_ff.pt_lo);
      p1_in.degen  = p0_ff.degen;
      p1_in.from_x = p0_ff.from_x;
      p1_in.from_y = p0_ff.from_y;
      p1_in.lf     = LEN_W'(sf >> (6'd14 + 6'(p0_ff.fs)));
      p1_in.lt     = LEN_W'(st >> (6'd14 + 6'(p0_ff.ts)));
      p1_in.af     = p0_ff.af;
      p1_in.rprod  = 50'(p0_ff.d) * 50'(p0_ff.rate);
   end

   // Mean length, target angle and quadrant fold of the unit vector.
   always_comb begin
      logic [31:0]        ph32;
      logic signed [33:0] phs;
      ph32 = p1_ff.af + p1_ff.rprod[45:14];
      phs  = 34'($signed(ph32));
      rs_in[0].degen  = p1_ff.degen;
      rs_in[0].from_x = p1_ff.from_x;
      rs_in[0].from_y = p1_ff.from_y;
      rs_in[0].mean   = LEN_W'(((LEN_W+1)'(p1_ff.lf) + (LEN_W+1)'(p1_ff.lt)) >> 1);
      if (phs > QTR) begin
         rs_in[0].x   = '0;
         rs_in[0].y   = ROT_W'(bvcr_pkg::KINV_Q30);
         rs_in[0].phi = phs - QTR;
      end else if (phs < -QTR) begin
         rs_in[0].x   = '0;
         rs_in[0].y   = -ROT_W'(bvcr_pkg::KINV_Q30);
         rs_in[0].phi = phs + QTR;
      end else begin
         rs_in[0].x   = ROT_W'(bvcr_pkg::KINV_Q30);
         rs_in[0].y   = '0;
         rs_in[0].phi = phs;
      end
      for (int k = 0; k < N; k++) begin
         rs_in[k+1] = rot_step(rs_ff[k], 5'(k));
      end
   end

   // Bring the mean below 2^31 so it fits the 31-bit scale operand t.
   always_comb begin
      logic [5:0] p;
      logic [4:0] e;
      p = '0;
      for (int b = 0; b < LEN_W; b++) begin
         if (rs_ff[N].mean[b]) p = 6'(b);
      end
      e = (p >= 6'd31) ? 5'(p - 6'd30) : '0;
      n0_in.degen  = rs_ff[N].degen;
      n0_in.from_x = rs_ff[N].from_x;
      n0_in.from_y = rs_ff[N].from_y;
      n0_in.t      = 31'(rs_ff[N].mean >> e);
      n0_in.e      = e;
      n0_in.x      = rs_ff[N].x;
      n0_in.y      = rs_ff[N].y;
   end

   always_comb begin
      m0_in.degen  = n0_ff.degen;
      m0_in.from_x = n0_ff.from_x;
      m0_in.from_y = n0_ff.from_y;
      m0_in.px     = $signed({35'd0, n0_ff.t}) * 66'(n0_ff.x);
      m0_in.py     = $signed({35'd0, n0_ff.t}) * 66'(n0_ff.y);
      m0_in.e      = n0_ff.e;
   end

   // Round half up, then saturate; zero-length items pass the from-vector.
   always_comb begin
      logic [5:0]         sh;
      logic signed [65:0] half;
      sh   = 6'd46 - 6'(m0_ff.e);
      half = 66'sd1 <<< (sh - 6'd1);
      if (m0_ff.degen) begin
         out_in.out_x = sat(66'(m0_ff.from_x));
         out_in.out_y = sat(66'(m0_ff.from_y));
      end else begin
         out_in.out_x = sat((m0_ff.px + half) >>> sh);
         out_in.out_y = sat((m0_ff.py + half) >>> sh);
      end
      out_in.degenerate = m0_ff.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vv_ff    <= '0;
         p0_v_ff  <= 1'b0;
         p1_v_ff  <= 1'b0;
         rv_ff    <= '0;
         n0_v_ff  <= 1'b0;
         m0_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         vv_ff    <= {vv_ff[N-1:0], job_valid};
         p0_v_ff  <= vv_ff[N];
         p1_v_ff  <= p0_v_ff;
         rv_ff    <= {rv_ff[N-1:0], p1_v_ff};
         n0_v_ff  <= rv_ff[N];
         m0_v_ff  <= n0_v_ff;
         out_v_ff <= m0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vs_ff  <= vs_in;
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         rs_ff  <= rs_in;
         n0_ff  <= n0_in;
         m0_ff  <= m0_in;
         out_ff <= out_in;
      end
   end

   `BVCR_ASSERT_NEXT(a_vec_hold, !adv, vv_ff == $past(vv_ff), "back: vectoring moved in stall")
   `BVCR_ASSERT_NEXT(a_rot_hold, !adv, rv_ff == $past(rv_ff), "back: rotation moved in stall")

endmodule

>>> hw/rtl/blend_vector_by_clockwise_rotation.sv
// Top level of the clockwise-rotation vector blend.
//
// Usage: one request transfer on req_if carries a from-vector, a to-vector (signed
// Q16.16) and a blend rate (signed Q2.14). Each request yields exactly one response
// transfer on rsp_if: the from-vector turned clockwise toward the to-vector by the
// rate times the clockwise angle, with the mean of the two lengths, saturated to
// COORD_WIDTH bits (at most 32). A zero-length input returns the from-vector with
// degenerate set.
// The vectoring and rotation CORDIC pipelines lie in series from request to response.
// Throughput: one item per cycle while no response is held; every stage is pipelined
// and no unit is shared.
// Reset: synchronous, active high; empties the front register, the job queue and all
// pipeline valids. No clearing pass is needed; requests are taken right after reset.
// Stall: a held response freezes the back pipeline; the queue then fills and the
// front drops req_if.ready once the queue and its own register are full.
module blend_vector_by_clockwise_rotation #(
   parameter int COORD_WIDTH   = bvcr_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = bvcr_pkg::CORDIC_STAGES_DEF
) (
   input logic          clock,
   input logic          reset,
   bvcr_chan_if.sink    req_if,
   bvcr_chan_if.source  rsp_if
);

   // Front to queue.
   logic              push;
   logic              full;
   bvcr_pkg::job_type push_data;

   // Queue to back.
   logic              pop;
   logic              empty;
   bvcr_pkg::job_type pop_data;

   // Classify and prescale; hold the request until the queue takes it.
   bvcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (req_if.data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   // Decouple front and back so each can stall on its own.
   bvcr_fifo #(
      .DEPTH (bvcr_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   // Measure, blend, rotate, rescale; the last stage is the response register.
   bvcr_back #(
      .COORD_WIDTH   (COORD_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!empty),
      .job_data  (pop_data),
      .job_pop   (pop),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_if.data)
   );

endmodule
